>>> design/floyd_steinberg_dither_assert.svh
// ----------------------------------------------------------------------------
// floyd_steinberg_dither assertion macros
// clocked concurrent assertion helpers, reset disables them
// ----------------------------------------------------------------------------
`ifndef FLOYD_STEINBERG_DITHER_ASSERT_SVH
`define FLOYD_STEINBERG_DITHER_ASSERT_SVH

// same-cycle implication
`define FSD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fsd assertion failed");

// next-cycle implication
`define FSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fsd assertion failed");

`endif

>>> design/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// shared constants, types and error-share arithmetic of the dither block
// ----------------------------------------------------------------------------
package fsd_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int ERR_W     = 9;
    localparam int WIDTH_W   = 13;
    localparam int HEIGHT_W  = 16;
    localparam int CFG_W     = 16;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_HEIGHT    = 2'd2;

    localparam logic [PIX_W-1:0]    RST_THRESHOLD = 8'd128;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH     = 13'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT    = 16'd480;

    typedef logic signed [ERR_W-1:0] t_err;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        t_err             above_left;
        t_err             above;
        t_err             above_right;
        t_err             left;
        logic             use_left;
        logic             interior;
        logic [PIX_W-1:0] threshold;
    } t_diffuse_in;

    typedef struct packed {
        logic white;
        t_err err;
    } t_diffuse_out;

    // err * k / 16, truncated toward zero
    function automatic t_err share(input t_err err, input logic [3:0] k);
        logic signed [12:0] prod;
        logic signed [12:0] adj;
        prod = 13'(err) * 13'(signed'({1'b0, k}));
        adj  = prod[12] ? prod + 13'sd15 : prod;
        return ERR_W'(adj >>> 4);
    endfunction

    function automatic logic [PIX_W-1:0] add_clamped(input logic [PIX_W-1:0] v,
                                                      input t_err s);
        logic signed [9:0] sum;
        sum = signed'({2'b00, v}) + 10'(s);
        if (sum < 10'sd0) begin
            return '0;
        end else if (sum > 10'sd255) begin
            return 8'd255;
        end
        return sum[7:0];
    endfunction

endpackage

>>> design/floyd_steinberg_dither.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_dither
// black/white error-diffusion dither of a raster-order gray pixel stream
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carry i_gray_pixel, one pixel per
// transaction in raster order. output channel: o_valid / i_stall carry
// o_is_white and o_end_of_frame, one result per input pixel, in order.
// a transaction completes on a clock edge with valid high and stall low.
// the result sits in the output register on the cycle after the pixel is
// taken. throughput is one pixel per cycle unless the receiver stalls; the row error
// ram has two read ports prefetched from the next column, so none waits on it.
// while the receiver stalls a full output register, o_stall is raised and
// the result holds; a result taken in the same cycle frees room at once.
// configuration writes (threshold, width, height) are taken on any edge
// with i_cfg_wr_en high; change them only between transactions.
// synchronous reset clears counters, diffusion state and the output valid
// flag and loads default configuration; the row ram is not cleared and
// needs no clearing pass, the first row never reads it.
// ----------------------------------------------------------------------------
module floyd_steinberg_dither (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [1:0]                     i_cfg_index,
    input  logic [fsd_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [fsd_pkg::PIX_W-1:0]      i_gray_pixel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_is_white,
    output logic                           o_end_of_frame
);
    import fsd_pkg::*;

    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
        if (w == '0) begin
            return WIDTH_W'(1);
        end else if (w > WIDTH_W'(MAX_WIDTH)) begin
            return WIDTH_W'(MAX_WIDTH);
        end
        return w;
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c,
                                                    input logic [WIDTH_W-1:0] w);
        if (WIDTH_W'(c) >= w) begin
            return COL_W'(w - WIDTH_W'(1));
        end
        return c;
    endfunction

    logic [PIX_W-1:0]    r_threshold;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [WIDTH_W-1:0]  n_width;

    logic [COL_W-1:0]    r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [COL_W-1:0]    n_col;
    logic [HEIGHT_W-1:0] n_row;
    t_err                r_above;
    t_err                r_left;

    t_err                mem [MAX_WIDTH];
    t_err                r_mem_a;
    t_err                r_mem_b;
    logic                r_fwd_a;
    logic                r_fwd_b;
    t_err                r_fwd_err;

    logic                r_out_valid;
    logic                r_is_white;
    logic                r_eof;

    logic                accept;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    x;
    logic                last_col;
    logic                last_row;
    logic                first_row;
    logic [COL_W-1:0]    rd_addr_a;
    logic [COL_W-1:0]    rd_addr_b;
    t_err                rd_a;
    t_err                rd_b;
    t_err                above_cur;

    t_diffuse_in         dif_req;
    t_diffuse_out        dif_rsp;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        w_eff     = eff_width(r_width);
        h_eff     = (r_height == '0) ? HEIGHT_W'(1) : r_height;
        x         = clamp_col(r_col, w_eff);
        last_col  = (WIDTH_W'(x) + WIDTH_W'(1)) >= w_eff;
        last_row  = (17'(r_row) + 17'd1) >= 17'(h_eff);
        first_row = r_row == '0;
        rd_a      = r_fwd_a ? r_fwd_err : r_mem_a;
        rd_b      = r_fwd_b ? r_fwd_err : r_mem_b;
        above_cur = first_row ? '0 : rd_a;
    end

    always_comb begin
        dif_req.pixel       = i_gray_pixel;
        dif_req.above_left  = (first_row || x == '0) ? '0 : r_above;
        dif_req.above       = above_cur;
        dif_req.above_right = (first_row || last_col) ? '0 : rd_b;
        dif_req.left        = r_left;
        dif_req.use_left    = x != '0;
        dif_req.interior    = (x != '0) && !last_col && !last_row;
        dif_req.threshold   = r_threshold;
    end

    fsd_diffuse u_diffuse (
        .i_req (dif_req),
        .o_rsp (dif_rsp)
    );

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + HEIGHT_W'(1);
            end else begin
                n_col = x + COL_W'(1);
            end
        end
        n_width = (i_cfg_wr_en && i_cfg_index == CFG_WIDTH) ?
                  i_cfg_data[WIDTH_W-1:0] : r_width;
        rd_addr_a = clamp_col(n_col, eff_width(n_width));
        rd_addr_b = rd_addr_a + COL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[x] <= dif_rsp.err;
        end
        r_mem_a   <= mem[rd_addr_a];
        r_mem_b   <= mem[rd_addr_b];
        r_fwd_err <= dif_rsp.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[PIX_W-1:0];
                CFG_WIDTH:     r_width     <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT:    r_height    <= i_cfg_data[HEIGHT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_above     <= '0;
            r_left      <= '0;
            r_fwd_a     <= 1'b0;
            r_fwd_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_fwd_a <= accept && (rd_addr_a == x);
            r_fwd_b <= accept && (rd_addr_b == x);
            if (accept) begin
                r_above     <= above_cur;
                r_left      <= dif_rsp.err;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_white <= dif_rsp.white;
            r_eof      <= last_col && last_row;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_white     = r_is_white;
    assign o_end_of_frame = r_eof;

endmodule

>>> design/fsd_diffuse.sv
// ----------------------------------------------------------------------------
// fsd_diffuse
// adds the incoming error shares, thresholds and forms the outgoing error
// ----------------------------------------------------------------------------
module fsd_diffuse (
    input  fsd_pkg::t_diffuse_in  i_req,
    output fsd_pkg::t_diffuse_out o_rsp
);
    import fsd_pkg::*;

    logic [PIX_W-1:0] v1;
    logic [PIX_W-1:0] v2;
    logic [PIX_W-1:0] v3;
    logic [PIX_W-1:0] v4;
    logic             white;

    always_comb begin
        v1    = add_clamped(i_req.pixel, share(i_req.above_left, 4'd1));
        v2    = add_clamped(v1, share(i_req.above, 4'd5));
        v3    = add_clamped(v2, share(i_req.above_right, 4'd3));
        v4    = i_req.use_left ? add_clamped(v3, share(i_req.left, 4'd7)) : v3;
        white = v4 > i_req.threshold;
        o_rsp.white = white;
        if (!i_req.interior) begin
            o_rsp.err = '0;
        end else if (white) begin
            o_rsp.err = signed'({1'b0, v4}) - 9'sd255;
        end else begin
            o_rsp.err = signed'({1'b0, v4});
        end
    end

endmodule

>>> design/fsd_checker.sv
// ----------------------------------------------------------------------------
// fsd_checker
// port-level checks of the dither block, bound to the top level
// ----------------------------------------------------------------------------
`include "floyd_steinberg_dither_assert.svh"

module fsd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_is_white,
    input logic o_end_of_frame
);

    // stalled result stays presented
    `FSD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)

    // stalled result payload does not change
    `FSD_ASSERT_NEXT(a_out_stable, o_valid && i_stall,
                     $stable(o_is_white) && $stable(o_end_of_frame))

    // every input transaction shows up as a result on the next cycle
    `FSD_ASSERT_NEXT(a_accept_to_out, i_valid && !o_stall, o_valid)

    // input is only held off by a full, stalled output register
    `FSD_ASSERT_IMPL(a_stall_cause, o_stall, o_valid && i_stall)

    // a new result needs an input transaction in the cycle before
    `FSD_ASSERT_IMPL(a_no_invented, o_valid && !$past(o_valid),
                     $past(i_valid) && !$past(o_stall))

endmodule

bind floyd_steinberg_dither fsd_checker u_fsd_checker (.*);

>>> dv/tb_floyd_steinberg_dither.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_floyd_steinberg_dither
// self-checking bench for the black/white error-diffusion dither block:
// a bit-accurate predictor of the diffusion, clamping and frame counters
// works out each pixel's result as it is taken. Small frames run with random
// content, bursty input and a patterned output stall. Register changes fall
// between frames and inside frames. An oversized width and a tall frame are
// each cut short once by a register change.
// ----------------------------------------------------------------------------
module tb_floyd_steinberg_dither;
    import fsd_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         RANDOM_PIXELS = 560;
    localparam int         HOLD_CYCLES   = 80;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic white;
        logic eof;
    } t_bw_result;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } t_rx_mode;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [1:0]          i_cfg_index    = CFG_THRESHOLD;
    logic [CFG_W-1:0]    i_cfg_data     = '0;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    t_pixel              i_gray_pixel   = '0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic                o_is_white;
    logic                o_end_of_frame;

    floyd_steinberg_dither u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_gray_pixel   (i_gray_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_white     (o_is_white),
        .o_end_of_frame (o_end_of_frame)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [PIX_W-1:0]    thr_q;
    logic [WIDTH_W-1:0]  width_q;
    logic [HEIGHT_W-1:0] height_q;
    t_err                err_row [MAX_WIDTH];
    int                  win_ul;
    int                  win_u;
    int                  win_ur;
    int                  left_err;
    int                  col_pos;
    int                  row_pos;

    t_pixel              pixel_q [$];
    t_pixel              batch [$];
    t_bw_result          bw_q [$];
    int                  fail_count;

    // sender and receiver pacing
    int                  burst_left;
    int                  gap_left;
    bit                  steady_send;
    int                  hold_requests;
    int                  hold_served;
    int                  hold_left;
    int                  seg_left;
    t_rx_mode            rx_mode;

    function automatic int clamp_pixel(input int v);
        if (v > 255) begin
            return 255;
        end else if (v < 0) begin
            return 0;
        end
        return v;
    endfunction

    function automatic t_bw_result dither_pixel(input t_pixel gray);
        int         w;
        int         h;
        int         x;
        int         y;
        int         v;
        int         err;
        bit         last_row;
        bit         interior;
        t_bw_result res;
        w = int'(width_q);
        h = int'(height_q);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        x = col_pos;
        if (x >= w) x = w - 1;
        y = row_pos;
        last_row = (y + 1 >= h);
        if (y > 0) begin
            win_ul = (x > 0) ? win_u : 0;
            win_u  = int'(err_row[x]);
            win_ur = (x + 1 < w) ? int'(err_row[x + 1]) : 0;
        end else begin
            win_ul = 0;
            win_u  = 0;
            win_ur = 0;
        end
        v = int'(gray);
        v = clamp_pixel(v + win_ul / 16);
        v = clamp_pixel(v + win_u * 5 / 16);
        v = clamp_pixel(v + win_ur * 3 / 16);
        if (x > 0) v = clamp_pixel(v + left_err * 7 / 16);
        res.white = (v > int'(thr_q));
        res.eof   = 1'b0;
        interior  = (x >= 1) && (x + 1 < w) && !last_row;
        err       = interior ? (v - (res.white ? 255 : 0)) : 0;
        err_row[x] = t_err'(err);
        left_err   = err;
        if (x + 1 >= w) begin
            col_pos = 0;
            if (last_row) begin
                row_pos = 0;
                res.eof = 1'b1;
            end else begin
                row_pos = y + 1;
            end
        end else begin
            col_pos = x + 1;
        end
        return res;
    endfunction

    function automatic t_pixel pick_pixel();
        int t;
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return t_pixel'($urandom_range(0, 1) ? 254 : 1);
            3, 4: begin
                t = int'(thr_q) + $urandom_range(0, 6) - 3;
                return t_pixel'(clamp_pixel(t));
            end
            default: return t_pixel'($urandom_range(0, 255));
        endcase
    endfunction

    // input side: bursts of transactions with random gaps
    always @(posedge i_clk) begin : drive
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                bw_q.push_back(dither_pixel(i_gray_pixel));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0 && !steady_send) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    i_valid      <= 1'b1;
                    i_gray_pixel <= pixel_q.pop_front();
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each transaction, stall on a pattern of its own
    always @(posedge i_clk) begin : watch
        t_bw_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (bw_q.size() == 0) begin
                    $error("result transaction with no pixel waiting");
                    fail_count++;
                end else begin
                    want = bw_q.pop_front();
                    if (o_is_white !== want.white) begin
                        $error("is_white expected %0b actual %0b", want.white, o_is_white);
                        fail_count++;
                    end
                    if (o_end_of_frame !== want.eof) begin
                        $error("end_of_frame expected %0b actual %0b", want.eof,
                               o_end_of_frame);
                        fail_count++;
                    end
                end
            end
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 150);
                    rx_mode  = t_rx_mode'($urandom_range(0, 3));
                end
                seg_left--;
                case (rx_mode)
                    RX_FREE:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:  i_stall <= !i_stall;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_THRESHOLD: thr_q    = data[PIX_W-1:0];
            CFG_WIDTH:     width_q  = data[WIDTH_W-1:0];
            CFG_HEIGHT:    height_q = data[HEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    // hand the batch to the sender and wait until every result is back
    task automatic run_batch();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        foreach (batch[k]) pixel_q.push_back(batch[k]);
        do begin
            @(negedge i_clk);
        end while (pixel_q.size() != 0 || i_valid || bw_q.size() != 0);
    endtask

    task automatic write_threshold(input int t);
        write_reg(CFG_THRESHOLD, {8'($urandom), 8'(t)});
    endtask

    task automatic write_width(input int w);
        write_reg(CFG_WIDTH, {3'($urandom), 13'(w)});
    endtask

    task automatic fill_random(input int count);
        batch = {};
        repeat (count) batch.push_back(pick_pixel());
    endtask

    initial begin : limit
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int  random_items;
        int  phase_no;
        int  w_eff;
        int  h_eff;
        int  frame_size;
        int  remaining;
        int  frames;
        int  count;
        bit  wide_done;
        bit  tall_done;

        thr_q    = RST_THRESHOLD;
        width_q  = RST_WIDTH;
        height_q = RST_HEIGHT;
        foreach (err_row[k]) err_row[k] = '0;
        win_ul = 0;
        win_u  = 0;
        win_ur = 0;
        left_err = 0;
        col_pos  = 0;
        row_pos  = 0;
        fail_count    = 0;
        burst_left    = 0;
        gap_left      = 0;
        steady_send   = 1'b0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        seg_left      = 0;
        rx_mode       = RX_FREE;
        random_items  = 0;
        phase_no      = 0;
        wide_done     = 1'b0;
        tall_done     = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // small frame with interior pixels, extremes on corners and edges
        write_threshold(128);
        write_width(4);
        write_reg(CFG_HEIGHT, 16'd3);
        batch = {8'd255, 8'd0, 8'd255, 8'd0,
                 8'd128, 8'd129, 8'd127, 8'd255,
                 8'd0, 8'd1, 8'd254, 8'd255};
        run_batch();

        // zero width and height act as one, unused index has no effect
        write_threshold(0);
        write_width(0);
        write_reg(CFG_HEIGHT, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        batch = {8'd0, 8'd1};
        run_batch();

        // single column, threshold at top
        write_threshold(255);
        write_width(1);
        write_reg(CFG_HEIGHT, 16'd2);
        batch = {8'd255, 8'd0};
        run_batch();

        // height and threshold change inside a frame
        write_threshold(100);
        write_width(3);
        write_reg(CFG_HEIGHT, 16'd4);
        batch = {8'd90, 8'd200, 8'd101, 8'd60};
        run_batch();
        write_threshold(20);
        write_reg(CFG_HEIGHT, 16'd2);
        batch = {8'd15, 8'd30};
        run_batch();

        // width shrinks inside a frame, current column becomes the last
        write_threshold(128);
        write_width(5);
        write_reg(CFG_HEIGHT, 16'd2);
        batch = {8'd200, 8'd100, 8'd140, 8'd20, 8'd255, 8'd70, 8'd180};
        run_batch();
        write_width(3);
        batch = {8'd128};
        run_batch();

        while (random_items < RANDOM_PIXELS) begin
            if (col_pos == 0 && row_pos == 0 && !wide_done && random_items > 200) begin
                // width beyond the ram size, cut short by a width change
                write_threshold($urandom_range(0, 255));
                write_reg(CFG_WIDTH, 16'hFFFF);
                write_reg(CFG_HEIGHT, 16'd1);
                fill_random(20);
                run_batch();
                write_width(3);
                fill_random(1);
                run_batch();
                wide_done = 1'b1;
                continue;
            end
            if (col_pos == 0 && row_pos == 0 && !tall_done && random_items > 400) begin
                // tallest frame, cut short by a height change
                write_threshold($urandom_range(0, 255));
                write_width(3);
                write_reg(CFG_HEIGHT, 16'hFFFF);
                fill_random(30);
                run_batch();
                write_reg(CFG_HEIGHT, 16'd1);
                fill_random(3);
                run_batch();
                tall_done = 1'b1;
                continue;
            end
            if (col_pos == 0 && row_pos == 0 && $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_width(0);
                    1:       write_width(1);
                    2:       write_width(2);
                    3:       write_width(3);
                    default: write_width($urandom_range(4, 12));
                endcase
                write_reg(CFG_HEIGHT, 16'($urandom_range(0, 6)));
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       write_threshold(0);
                    1:       write_threshold(255);
                    default: write_threshold($urandom_range(0, 255));
                endcase
            end
            w_eff = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q));
            h_eff = (height_q == 0) ? 1 : int'(height_q);
            frame_size = w_eff * h_eff;
            remaining  = (col_pos == 0 && row_pos == 0) ? 0 :
                         (h_eff - row_pos) * w_eff - col_pos;
            frames = $urandom_range(1, 3);
            if (phase_no == 1) frames = 120 / frame_size + 1;
            count = remaining + frames * frame_size;
            if (frame_size > 1 && $urandom_range(0, 2) == 0) begin
                count += $urandom_range(1, frame_size - 1);
            end
            fill_random(count);
            if (phase_no == 1) begin
                // long output hold-off against a steady input
                steady_send = 1'b1;
                hold_requests++;
            end
            run_batch();
            steady_send = 1'b0;
            random_items += count;
            phase_no++;
        end

        repeat (10) @(posedge i_clk);
        if (bw_q.size() != 0) begin
            $error("%0d results never arrived", bw_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/fsd_pkg.sv
design/fsd_diffuse.sv
design/floyd_steinberg_dither.sv
design/fsd_checker.sv
dv/tb_floyd_steinberg_dither.sv
